@@ src/lbpt_pkg.sv @@
// Shared types, class and action codes, and the UAX#14 pair table for the
// line-break pair table resolver. No dependencies.
`default_nettype none

package lbpt_pkg;

	// Break actions as given on the result channel
	typedef enum logic [2:0] {
		ACT_DIR  = 3'd0,
		ACT_IND  = 3'd1,
		ACT_CIND = 3'd2,
		ACT_CPRO = 3'd3,
		ACT_PRO  = 3'd4,
		ACT_EXP  = 3'd5
	} lbpt_action_t;

	// Line-break classes used by name; all but WJ lie outside the pair table
	localparam logic [4:0] CLS_WJ = 5'd20;
	localparam logic [4:0] CLS_SP = 5'd26;
	localparam logic [4:0] CLS_SA = 5'd27;
	localparam logic [4:0] CLS_BK = 5'd28;
	localparam logic [4:0] CLS_CR = 5'd29;
	localparam logic [4:0] CLS_LF = 5'd30;
	localparam logic [4:0] CLS_NL = 5'd31;

	// Classes covered by the pair table (OP..JT)
	localparam int NTAB = 26;

	// Result FIFO depth (power of two)
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// One result item
	typedef struct packed {
		lbpt_action_t action;
		logic         break_allowed;
		logic         last_result;
	} lbpt_res_t;

	// Resolver state carried between items
	typedef struct packed {
		logic         at_start;
		logic [4:0]   ctx;
		logic [4:0]   prev;
		logic [4:0]   prev2;
		lbpt_action_t pend_act;
		logic         pend_valid;
	} lbpt_state_t;

	// Pair table: one row per class before the boundary, one nibble per class
	// after it, column OP in the top nibble
	localparam logic [4*NTAB-1:0] PAIR_TAB [NTAB] = '{
		104'h44444444444444444443444444,
		104'h04114444111100110042400000,
		104'h44111444111111111142411111,
		104'h14111444111111111142411111,
		104'h04111444000000110042400000,
		104'h04111444000000110042400000,
		104'h04111444001000110042400000,
		104'h04111444001100110042400000,
		104'h14111444001110110042411111,
		104'h14111444001100110042400000,
		104'h14111444111101110042400000,
		104'h14111444001101110042400000,
		104'h04111444010001110042400000,
		104'h04111444000001110042400000,
		104'h04101444001000110042400000,
		104'h04101444000000110042400000,
		104'h14111444111111111142411111,
		104'h04111444000000110442400000,
		104'h00000000000000000040000000,
		104'h04111444001101110042400000,
		104'h14111444111111111142411111,
		104'h04111444010001110042400011,
		104'h04111444010001110042400001,
		104'h04111444010001110042411110,
		104'h04111444010001110042400011,
		104'h04111444010001110042400001
	};

	// Table lookup; row and column must both be below NTAB
	function automatic lbpt_action_t pair_lookup(input logic [4:0] row, input logic [4:0] col);
		logic [4*NTAB-1:0] row_bits;
		logic [6:0]        base;
		row_bits = PAIR_TAB[row];
		base     = 7'((NTAB - 1 - int'(col)) * 4);
		return lbpt_action_t'(row_bits[base +: 3]);
	endfunction

endpackage

`default_nettype wire

@@ src/lbpt_step.sv @@
// Combinational resolver step: one class against the carried state gives up
// to two result items and the next state. Depends on lbpt_pkg.
`default_nettype none

module lbpt_step import lbpt_pkg::*; (
	input  lbpt_state_t  st,
	input  logic [4:0]   char_class,
	input  logic         last_char,
	input  logic         legacy_cm,
	output lbpt_state_t  nxt,
	output lbpt_res_t    res0,
	output lbpt_res_t    res1,
	output logic [1:0]   res_n
);

	function automatic lbpt_res_t mk_res(input lbpt_action_t act, input logic lst);
		lbpt_res_t r;
		r.action        = act;
		r.break_allowed = (act != ACT_CPRO) && (act != ACT_PRO);
		r.last_result   = lst;
		return r;
	endfunction

	logic         brk, start, rewrite, hold, defer;
	logic         av, bv;
	lbpt_action_t t, b, pa, bact;
	logic [4:0]   nctx, run_ctx;
	lbpt_res_t    ra, rb, rc;

	always_comb begin
		// run ends after BK, or after CR not followed by LF
		brk   = !st.at_start && (st.ctx == CLS_BK || (st.ctx == CLS_CR && char_class != CLS_LF));
		start = st.at_start || brk;

		t = ((st.ctx < 5'(NTAB)) && (char_class < 5'(NTAB))) ?
			pair_lookup(st.ctx, char_class) : ACT_PRO;

		// boundary action and new context inside a run
		b       = ACT_PRO;
		nctx    = st.ctx;
		rewrite = 1'b0;
		if (char_class == CLS_SP) begin
			nctx = st.ctx;
		end else if (char_class == CLS_BK || char_class == CLS_NL || char_class == CLS_LF) begin
			nctx = CLS_BK;
		end else if (char_class == CLS_CR) begin
			nctx = CLS_CR;
		end else if (st.ctx == CLS_SA || char_class == CLS_SA) begin
			nctx = char_class;
		end else begin
			case (t)
				ACT_IND: begin
					b    = (st.prev == CLS_SP) ? ACT_IND : ACT_PRO;
					nctx = char_class;
				end
				ACT_CPRO: begin
					b = ACT_CPRO;
					if (st.prev == CLS_SP) nctx = char_class;
				end
				ACT_CIND: begin
					if (st.prev == CLS_SP) begin
						if (!legacy_cm) b = ACT_CIND;
						else rewrite = st.pend_valid;
						nctx = char_class;
					end
				end
				default: begin
					b    = t;
					nctx = char_class;
				end
			endcase
		end

		// legacy rewrite of the held boundary before the space
		pa = (!start && rewrite) ? ((st.prev2 == CLS_SP) ? ACT_IND : ACT_DIR) : st.pend_act;

		// boundary before a space is held back in legacy mode
		hold = !start && legacy_cm && (char_class == CLS_SP) && !last_char;

		av   = st.pend_valid;
		bv   = start ? brk : !hold;
		bact = start ? ACT_EXP : b;
		ra   = mk_res(pa, pa == ACT_EXP);
		rb   = mk_res(bact, 1'b0);
		rc   = mk_res(ACT_EXP, 1'b1);

		// pack the first two of held, own and closing items
		res0  = rc;
		res1  = rc;
		res_n = 2'd0;
		if (av) begin
			res0 = ra;
			if (bv) begin
				res1  = rb;
				res_n = 2'd2;
			end else if (last_char) begin
				res_n = 2'd2;
			end else begin
				res_n = 2'd1;
			end
		end else if (bv) begin
			res0 = rb;
			res_n = last_char ? 2'd2 : 2'd1;
		end else if (last_char) begin
			res_n = 2'd1;
		end
		defer = last_char && av && bv;

		// next state
		case (char_class)
			CLS_LF, CLS_NL: run_ctx = CLS_BK;
			CLS_SP:         run_ctx = CLS_WJ;
			default:        run_ctx = char_class;
		endcase
		nxt.at_start = last_char;
		nxt.ctx      = start ? run_ctx : nctx;
		nxt.prev     = char_class;
		nxt.prev2    = start ? 5'd0 : st.prev;
		if (defer) begin
			nxt.pend_act   = ACT_EXP;
			nxt.pend_valid = 1'b1;
		end else if (hold) begin
			nxt.pend_act   = b;
			nxt.pend_valid = 1'b1;
		end else begin
			nxt.pend_act   = pa;
			nxt.pend_valid = 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ src/lbpt_out_fifo.sv @@
// Result FIFO: takes up to two items a cycle, gives one a cycle while out_ready is high.
// Depends on lbpt_pkg.
`default_nettype none

module lbpt_out_fifo import lbpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lbpt_res_t  push0,
	input  lbpt_res_t  push1,
	input  logic [1:0] push_n,
	output logic       room2,
	output logic       out_valid,
	input  logic       out_ready,
	output lbpt_res_t  head
);

	lbpt_res_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	assign room2     = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));

	// storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= push0;
		if (push_n == 2'd2) mem_q[wr_ptr_q + FIFO_AW'(1)] <= push1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

endmodule

`default_nettype wire

@@ src/line_break_pair_table_resolver.sv @@
// Top level of the line-break pair table resolver: input register, state,
// configuration port and result FIFO. Depends on lbpt_pkg, lbpt_step, lbpt_out_fifo.
//
// One character class is taken per cycle into an input register; the pair
// table lookup and the boundary rules are resolved from that register, and
// the up to two result items it causes are written into a four-entry result
// FIFO once that has room for two results. Items enter at one per cycle as
// long as the FIFO has room for two results; since the output gives one
// result per cycle while out_ready is high, the sustained rate is one item
// per cycle while items cause at most one result on average. The
// legacy_cm register (byte address 0) must be written only while the block is
// idle.
`default_nettype none

module line_break_pair_table_resolver import lbpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  char_class,
	input  logic        last_char,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic        break_allowed,
	output logic        last_result
);

	logic        legacy_cm_q;
	logic        valid_s1;
	logic [4:0]  class_s1;
	logic        last_s1;
	lbpt_state_t state_q, state_nxt;
	lbpt_res_t   res0, res1, head;
	logic [1:0]  res_n;
	logic        room2, go;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, legacy_cm_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			legacy_cm_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			legacy_cm_q <= pwdata[0];
		end
	end

	// input register: resolved once the FIFO has room for two items
	assign go       = valid_s1 && room2;
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			class_s1 <= char_class;
			last_s1  <= last_char;
		end
	end

	// resolver step
	lbpt_step u_step (
		.st         (state_q),
		.char_class (class_s1),
		.last_char  (last_s1),
		.legacy_cm  (legacy_cm_q),
		.nxt        (state_nxt),
		.res0       (res0),
		.res1       (res1),
		.res_n      (res_n)
	);

	// carried state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.at_start   <= 1'b1;
			state_q.ctx        <= 5'd0;
			state_q.prev       <= 5'd0;
			state_q.prev2      <= 5'd0;
			state_q.pend_act   <= ACT_DIR;
			state_q.pend_valid <= 1'b0;
		end else if (go) begin
			state_q <= state_nxt;
		end
	end

	// result FIFO
	lbpt_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (res0),
		.push1     (res1),
		.push_n    (go ? res_n : 2'd0),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign action        = head.action;
	assign break_allowed = head.break_allowed;
	assign last_result   = head.last_result;

endmodule

`default_nettype wire

@@ src/lbpt_checker.sv @@
// Port-level checks for the line-break pair table resolver, bound to the top
// level. Depends on lbpt_pkg and line_break_pair_table_resolver.
`default_nettype none

module lbpt_checker import lbpt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] action,
	input logic       break_allowed,
	input logic       last_result
);

	// a stalled item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(last_result))
		else $error("result item changed while stalled");

	// break flag follows the action
	a_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (break_allowed == (action != ACT_CPRO && action != ACT_PRO)))
		else $error("break_allowed disagrees with action");

	// no undefined action codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action <= ACT_EXP))
		else $error("undefined action code");

	// the closing item is always an explicit break
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> (action == ACT_EXP))
		else $error("closing item is not an explicit break");

endmodule

bind line_break_pair_table_resolver lbpt_checker u_lbpt_checker (.*);

`default_nettype wire

@@ tb/tb_line_break_pair_table_resolver.sv @@
// Self-checking testbench for line_break_pair_table_resolver: a boundary predictor
// class tracks each accepted item and checks every result item. Needs lbpt_pkg.
`timescale 1ns / 1ps

module tb_line_break_pair_table_resolver import lbpt_pkg::*;;

	// Classes used by name in the stimulus
	localparam logic [4:0] CLS_OP = 5'd0;
	localparam logic [4:0] CLS_CL = 5'd1;
	localparam logic [4:0] CLS_NU = 5'd10;
	localparam logic [4:0] CLS_AL = 5'd11;
	localparam logic [4:0] CLS_ID = 5'd12;
	localparam logic [4:0] CLS_HY = 5'd14;
	localparam logic [4:0] CLS_CM = 5'd19;
	localparam logic [4:0] CLS_JT = 5'd25;

	localparam logic [2:0] REG_LEGACY_CM = 3'd0;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 100;

	// Break actions per pair: row is the class before, OP in the top nibble
	localparam logic [4*NTAB-1:0] BREAK_PAIRS [NTAB] = '{
		104'h44444444444444444443444444,
		104'h04114444111100110042400000,
		104'h44111444111111111142411111,
		104'h14111444111111111142411111,
		104'h04111444000000110042400000,
		104'h04111444000000110042400000,
		104'h04111444001000110042400000,
		104'h04111444001100110042400000,
		104'h14111444001110110042411111,
		104'h14111444001100110042400000,
		104'h14111444111101110042400000,
		104'h14111444001101110042400000,
		104'h04111444010001110042400000,
		104'h04111444000001110042400000,
		104'h04101444001000110042400000,
		104'h04101444000000110042400000,
		104'h14111444111111111142411111,
		104'h04111444000000110442400000,
		104'h00000000000000000040000000,
		104'h04111444001101110042400000,
		104'h14111444111111111142411111,
		104'h04111444010001110042400011,
		104'h04111444010001110042400001,
		104'h04111444010001110042411110,
		104'h04111444010001110042400011,
		104'h04111444010001110042400001
	};

	typedef struct {
		lbpt_action_t act;
		logic         allowed;
		logic         closing;
	} boundary_t;

	// Predicts the boundaries each character causes and checks them in order
	class boundary_tracker;
		boundary_t    exp_boundaries[$];
		int           errors;
		logic         legacy;
		logic         at_start;
		logic [4:0]   ctx;
		logic [4:0]   prev;
		logic [4:0]   prev2;
		lbpt_action_t held_act;
		logic         held_valid;
		int           n_step;

		function new();
			errors     = 0;
			legacy     = 1'b0;
			at_start   = 1'b1;
			ctx        = '0;
			prev       = '0;
			prev2      = '0;
			held_act   = ACT_DIR;
			held_valid = 1'b0;
		endfunction

		function void set_legacy(input logic v);
			legacy = v;
		endfunction

		function int outstanding();
			return exp_boundaries.size();
		endfunction

		function lbpt_action_t pair_action(input logic [4:0] r, input logic [4:0] c);
			logic [4*NTAB-1:0] row;
			row = BREAK_PAIRS[r];
			return lbpt_action_t'(row[(NTAB - 1 - int'(c)) * 4 +: 3]);
		endfunction

		// At most two results per item
		function void add_result(input lbpt_action_t a, input logic closing);
			boundary_t e;
			if (n_step >= 2)
				return;
			e.act     = a;
			e.allowed = (a != ACT_CPRO && a != ACT_PRO);
			e.closing = closing;
			exp_boundaries.push_back(e);
			n_step++;
		endfunction

		function void release_held();
			if (held_valid) begin
				add_result(held_act, held_act == ACT_EXP);
				held_valid = 1'b0;
			end
		endfunction

		// Note one accepted item and queue the results it causes
		function void take_char(input logic [4:0] c, input logic last);
			logic [4:0]   ctx_old;
			logic [4:0]   prv;
			lbpt_action_t b;
			lbpt_action_t t;
			ctx_old = ctx;
			prv     = prev;
			b       = ACT_PRO;
			n_step  = 0;

			// hard break closes the run before this character
			if (!at_start && (ctx_old == CLS_BK || (ctx_old == CLS_CR && c != CLS_LF))) begin
				release_held();
				add_result(ACT_EXP, 1'b0);
				at_start = 1'b1;
			end

			if (at_start) begin
				release_held();
				if (c == CLS_LF || c == CLS_NL)
					ctx = CLS_BK;
				else if (c == CLS_SP)
					ctx = CLS_WJ;
				else
					ctx = c;
				prev     = c;
				prev2    = '0;
				at_start = 1'b0;
			end else begin
				if (c == CLS_SP) begin
					b = ACT_PRO;
				end else if (c == CLS_BK || c == CLS_NL || c == CLS_LF) begin
					ctx = CLS_BK;
				end else if (c == CLS_CR) begin
					ctx = CLS_CR;
				end else if (ctx_old == CLS_SA || c == CLS_SA) begin
					ctx = c;
				end else begin
					t = (ctx_old < NTAB && c < NTAB) ? pair_action(ctx_old, c) : ACT_PRO;
					case (t)
						ACT_IND: begin
							b   = (prv == CLS_SP) ? ACT_IND : ACT_PRO;
							ctx = c;
						end
						ACT_CPRO: begin
							b = ACT_CPRO;
							if (prv == CLS_SP)
								ctx = c;
						end
						ACT_CIND: begin
							if (prv == CLS_SP) begin
								// legacy mode glues SP to CM and rewrites the held boundary
								if (!legacy)
									b = ACT_CIND;
								else if (held_valid)
									held_act = (prev2 == CLS_SP) ? ACT_IND : ACT_DIR;
								ctx = c;
							end
						end
						default: begin
							b   = t;
							ctx = c;
						end
					endcase
				end
				release_held();
				if (legacy && c == CLS_SP && !last) begin
					held_act   = b;
					held_valid = 1'b1;
				end else begin
					add_result(b, 1'b0);
				end
				prev2 = prv;
				prev  = c;
			end

			// closing break, deferred when the item already gave two results
			if (last) begin
				if (n_step < 2) begin
					add_result(ACT_EXP, 1'b1);
				end else begin
					held_act   = ACT_EXP;
					held_valid = 1'b1;
				end
				at_start = 1'b1;
			end
		endfunction

		// Compare one result item with the oldest expected boundary
		function void check_boundary(input logic [2:0] a, input logic ba, input logic lr);
			boundary_t e;
			if (exp_boundaries.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, action %0d allowed %0d last %0d",
						$time, a, ba, lr);
				return;
			end
			e = exp_boundaries.pop_front();
			if (a !== e.act || ba !== e.allowed || lr !== e.closing) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: expected action %0d allowed %0d last %0d, got %0d %0d %0d",
						$time, e.act, e.allowed, e.closing, a, ba, lr);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  char_class = '0;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  action;
	logic        break_allowed;
	logic        last_result;

	boundary_tracker sb;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	int recv_stall = 0;
	int cycles = 0;

	line_break_pair_table_resolver dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_class(char_class), .last_char(last_char),
		.out_valid(out_valid), .out_ready(out_ready),
		.action(action), .break_allowed(break_allowed), .last_result(last_result)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Result side: check accepted items, then pick the next ready
	always @(posedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_boundary(action, break_allowed, last_result);
			if ($urandom_range(0, 149) == 0)
				recv_steady = !recv_steady;
			if (recv_stall > 0) begin
				recv_stall--;
				rdy = 1'b0;
			end else if (recv_steady) begin
				rdy = 1'b1;
			end else begin
				recv_stall = idle_cycles();
				rdy = (recv_stall == 0);
			end
			out_ready <= rdy;
		end
	end

	task automatic send_item(input logic [4:0] c, input logic last);
		int gap;
		char_class <= c;
		last_char  <= last;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.take_char(c, last);
		if ($urandom_range(0, 99) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain all expected results and let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== data) begin
			sb.errors++;
			$display("%0t: register read expected %0h got %0h", $time, data, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_legacy(input logic v);
		apb_write(REG_LEGACY_CM, {31'b0, v});
		sb.set_legacy(v);
		apb_check(REG_LEGACY_CM, {31'b0, v});
	endtask

	// Text-like class mix; SP is often followed by CM
	function automatic logic [4:0] pick_class(input logic [4:0] prev_cls);
		int r;
		r = $urandom_range(0, 99);
		if (prev_cls == CLS_SP && r < 40)
			return (r < 28) ? CLS_CM : CLS_SP;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 5'($urandom_range(0, NTAB - 1));
		if (r < 68)
			return CLS_SP;
		if (r < 76)
			return CLS_CM;
		if (r < 83)
			return CLS_SA;
		if (r < 87)
			return CLS_BK;
		if (r < 93)
			return CLS_CR;
		if (r < 97)
			return CLS_LF;
		return CLS_NL;
	endfunction

	// Mostly whole texts ending on a final character, some noise items
	task automatic run_texts(input int count);
		int done;
		int len;
		logic [4:0] c;
		logic [4:0] prev_cls;
		done     = 0;
		prev_cls = CLS_AL;
		while (done < count) begin
			if ($urandom_range(0, 9) == 0) begin
				c = 5'($urandom);
				send_item(c, 1'($urandom));
				prev_cls = c;
				done++;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					c = pick_class(prev_cls);
					send_item(c, i == len - 1);
					prev_cls = c;
				end
				done += len;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, normal mode: run starts, spaces, SA, CR/LF, hard breaks
		apply_legacy(1'b0);
		send_item(CLS_SP, 1'b0);
		send_item(CLS_OP, 1'b0);
		send_item(CLS_CL, 1'b0);
		send_item(CLS_SP, 1'b0);
		send_item(CLS_CM, 1'b0);
		send_item(CLS_HY, 1'b0);
		send_item(CLS_SA, 1'b0);
		send_item(CLS_NU, 1'b0);
		send_item(CLS_SA, 1'b0);
		send_item(CLS_CR, 1'b0);
		send_item(CLS_LF, 1'b0);
		send_item(CLS_ID, 1'b0);
		send_item(CLS_BK, 1'b0);
		send_item(CLS_NL, 1'b0);
		send_item(CLS_AL, 1'b1);
		settle();

		// Directed, legacy mode: SP CM rewrites, CR without LF, deferred closing break
		apply_legacy(1'b1);
		send_item(CLS_AL, 1'b0);
		send_item(CLS_SP, 1'b0);
		send_item(CLS_CM, 1'b0);
		send_item(CLS_SP, 1'b0);
		send_item(CLS_SP, 1'b0);
		send_item(CLS_CM, 1'b0);
		send_item(CLS_CR, 1'b0);
		send_item(CLS_AL, 1'b0);
		send_item(CLS_SP, 1'b0);
		send_item(CLS_JT, 1'b1);
		send_item(CLS_SP, 1'b1);
		// leave a space boundary held across the register change
		send_item(CLS_AL, 1'b0);
		send_item(CLS_SP, 1'b0);
		settle();

		// Random phases, legacy mode switched between them
		for (int p = 0; p < 10; p++) begin
			apply_legacy((p < 2) ? 1'(p) : 1'($urandom_range(0, 1)));
			run_texts(130);
			settle();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
